// File: hw/rtl/vcs_pkg.sv
// ----------------------------------------------------------------------------
// vcs_pkg: shared definitions of the voxel concentration store
// Field widths, request kind codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package vcs_pkg;

    localparam int DATA_W = 32;
    localparam int IDX_W  = 15;
    localparam int KIND_W = 3;
    localparam int RES_W  = 6;
    localparam int CFG_W  = 3;

    localparam int DEFAULT_MAX_RES   = 32;
    localparam int DEFAULT_FRAC_BITS = 16;

    localparam logic [KIND_W-1:0] KIND_WRITE    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ADD      = 3'd1;
    localparam logic [KIND_W-1:0] KIND_MUL      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_LOGISTIC = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_GRAD     = 3'd5;

    localparam logic [CFG_W-1:0] CFG_GRID_RES  = 3'd0;
    localparam logic [CFG_W-1:0] CFG_LOWER     = 3'd1;
    localparam logic [CFG_W-1:0] CFG_UPPER     = 3'd2;
    localparam logic [CFG_W-1:0] CFG_INV_LEN   = 3'd3;
    localparam logic [CFG_W-1:0] CFG_INV_VOL   = 3'd4;

    localparam logic [RES_W-1:0]         RST_GRID_RES = 6'd16;
    localparam logic signed [DATA_W-1:0] RST_LOWER    = 32'sd0;
    localparam logic signed [DATA_W-1:0] RST_UPPER    = 32'sh7FFF_FFFF;
    localparam logic [DATA_W-1:0]        RST_INV_LEN  = 32'd65536;
    localparam logic [DATA_W-1:0]        RST_INV_VOL  = 32'd65536;

endpackage

// File: hw/rtl/vcs_div.sv
// ----------------------------------------------------------------------------
// vcs_div: restoring integer divider
// Produces one quotient bit per cycle; done pulses when the result is ready.
// ----------------------------------------------------------------------------
module vcs_div
    import vcs_pkg::*;
#(
    parameter int DIVIDEND_W = IDX_W,
    parameter int DIVISOR_W  = 6
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient,
    output logic [DIVISOR_W-1:0]  remainder
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  run_reg;
    logic                  done_reg;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diffv;
    logic                  fits;

    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diffv = trial - {1'b0, divisor};
    assign fits  = trial >= {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DIVIDEND_W);
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // The partial remainder stays below the divisor whenever the divisor is nonzero.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (run_reg)
        begin
            rem_reg <= fits ? diffv[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: hw/rtl/voxel_concentration_store_unit.sv
// ----------------------------------------------------------------------------
// voxel_concentration_store_unit: cubic grid of Q16.16 concentrations
// Clamped writes, additive/multiplicative/logistic changes, value reads and
// central-difference gradient reads; scaling, products and gradients share one multiplier.
// ----------------------------------------------------------------------------
// An item passes the index check (ST_RR, ST_TOT, ST_CHK); an index outside the
// grid goes straight to ST_FIN. Otherwise the box is read, an amount to be volume
// scaled is scaled, and a product runs through ST_MUL, ST_RND and ST_POST before
// ST_WB; the divider splits a gradient's index into x, y and z before six reads.
// One item is in work at a time; a finished result waits in the output
// register. After reset every word of the store is cleared before items are taken.
module voxel_concentration_store_unit
    import vcs_pkg::*;
#(
    parameter int MAX_RESOLUTION = DEFAULT_MAX_RES,
    parameter int FRAC_BITS      = DEFAULT_FRAC_BITS
)(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_W-1:0]         cfg_index,
    input  logic [DATA_W-1:0]        cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [KIND_W-1:0]        kind,
    input  logic [IDX_W-1:0]         box_index,
    input  logic signed [DATA_W-1:0] amount,
    input  logic                     scale_by_volume,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     status,
    output logic signed [DATA_W-1:0] value,
    output logic signed [DATA_W-1:0] grad_x,
    output logic signed [DATA_W-1:0] grad_y,
    output logic signed [DATA_W-1:0] grad_z
);

    // Store geometry and datapath widths.
    localparam int DEPTH  = MAX_RESOLUTION * MAX_RESOLUTION * MAX_RESOLUTION;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int R_W    = $clog2(MAX_RESOLUTION + 1);
    localparam int RR_W   = 2 * R_W;
    localparam int TOT_W  = 3 * R_W;
    localparam int CMP_W  = (TOT_W > IDX_W) ? TOT_W : IDX_W;
    localparam int NB_W   = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;
    localparam int MAG_W  = DATA_W + 1;
    localparam int PROD_W = MAG_W + DATA_W;
    localparam int RND_W  = PROD_W + 1;
    localparam int WIDE_W = RND_W + 1;

    localparam logic [PROD_W:0] HALF_LSB  = (PROD_W + 1)'(1) << (FRAC_BITS - 1);
    localparam logic [PROD_W:0] HALF_LSB2 = (PROD_W + 1)'(1) << FRAC_BITS;
    localparam logic signed [WIDE_W-1:0] SAT_HI = (WIDE_W'(1) << (DATA_W - 1)) - WIDE_W'(1);
    localparam logic signed [WIDE_W-1:0] SAT_LO = -(WIDE_W'(1) << (DATA_W - 1));

    // Sequencer states.
    localparam logic [4:0] ST_CLEAR = 5'd0;
    localparam logic [4:0] ST_IDLE  = 5'd1;
    localparam logic [4:0] ST_RR    = 5'd2;
    localparam logic [4:0] ST_TOT   = 5'd3;
    localparam logic [4:0] ST_CHK   = 5'd4;
    localparam logic [4:0] ST_LOADC = 5'd5;
    localparam logic [4:0] ST_OPSEL = 5'd6;
    localparam logic [4:0] ST_MUL   = 5'd7;
    localparam logic [4:0] ST_RND   = 5'd8;
    localparam logic [4:0] ST_POST  = 5'd9;
    localparam logic [4:0] ST_WB    = 5'd10;
    localparam logic [4:0] ST_DV1   = 5'd11;
    localparam logic [4:0] ST_DV1W  = 5'd12;
    localparam logic [4:0] ST_DV2   = 5'd13;
    localparam logic [4:0] ST_DV2W  = 5'd14;
    localparam logic [4:0] ST_GSET  = 5'd15;
    localparam logic [4:0] ST_GRDH  = 5'd16;
    localparam logic [4:0] ST_GRDL  = 5'd17;
    localparam logic [4:0] ST_GDIF  = 5'd18;
    localparam logic [4:0] ST_FIN   = 5'd19;

    // What the shared multiplier is working on.
    localparam logic [1:0] PH_SCALE = 2'd0;
    localparam logic [1:0] PH_PROD  = 2'd1;
    localparam logic [1:0] PH_GRAD  = 2'd2;

    localparam logic [1:0] AX_Z = 2'd2;

    // Magnitude of a signed value one bit wider than the data.
    function automatic logic [MAG_W-1:0] mag_of(input logic signed [MAG_W-1:0] v);
        return v[MAG_W-1] ? MAG_W'(-v) : MAG_W'(v);
    endfunction

    // Shift a product magnitude right, rounding half away from zero, and
    // restore its sign. The extra bit shifts one more place (span of two).
    function automatic logic signed [RND_W-1:0] round_shift(
        input logic              neg,
        input logic [PROD_W-1:0] mag,
        input logic              extra
    );
        logic [PROD_W:0] sum0;
        logic [PROD_W:0] sum1;
        logic [PROD_W:0] sh;
        sum0 = {1'b0, mag} + HALF_LSB;
        sum1 = {1'b0, mag} + HALF_LSB2;
        sh   = extra ? (sum1 >> (FRAC_BITS + 1)) : (sum0 >> FRAC_BITS);
        return neg ? RND_W'(-$signed(sh)) : RND_W'($signed(sh));
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
        if (x > SAT_HI)
        begin
            return SAT_HI[DATA_W-1:0];
        end
        if (x < SAT_LO)
        begin
            return SAT_LO[DATA_W-1:0];
        end
        return x[DATA_W-1:0];
    endfunction

    // When the thresholds are crossed, the upper one wins for a value above it; every other value takes the lower one.
    function automatic logic signed [DATA_W-1:0] clamp_thr(
        input logic signed [WIDE_W-1:0] x,
        input logic signed [DATA_W-1:0] lo,
        input logic signed [DATA_W-1:0] hi
    );
        if (x > WIDE_W'(hi))
        begin
            return hi;
        end
        if (x < WIDE_W'(lo))
        begin
            return lo;
        end
        return x[DATA_W-1:0];
    endfunction

    // Configuration registers.
    logic [RES_W-1:0]         grid_res_reg;
    logic signed [DATA_W-1:0] lower_reg;
    logic signed [DATA_W-1:0] upper_reg;
    logic [DATA_W-1:0]        inv_len_reg;
    logic [DATA_W-1:0]        inv_vol_reg;

    // Sequencer and control.
    logic [4:0]        st_reg;
    logic [4:0]        st_next;
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [1:0]        ph_reg;
    logic [1:0]        ax_reg;
    logic              out_valid_reg;
    logic              in_acc;
    logic              fin_load;
    logic              idx_err;
    logic              scale_now;

    // Item and working registers.
    logic [KIND_W-1:0]        kind_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic signed [DATA_W-1:0] a_reg;
    logic                     scale_reg;
    logic [RR_W-1:0]          rr_reg;
    logic [TOT_W-1:0]         tot_reg;
    logic signed [DATA_W-1:0] c_reg;
    logic signed [MAG_W-1:0]  t_reg;
    logic signed [DATA_W-1:0] hv_reg;
    logic signed [MAG_W-1:0]  diff_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic                     neg_reg;
    logic signed [RND_W-1:0]  rnd_reg;
    logic [R_W-1:0]           x_reg;
    logic [R_W-1:0]           y_reg;
    logic [R_W-1:0]           z_reg;
    logic [IDX_W-1:0]         q1_reg;
    logic [2:0]               okm_reg;
    logic [2:0]               okp_reg;

    // Result staging and output registers.
    logic                     res_status_reg;
    logic signed [DATA_W-1:0] res_value_reg;
    logic signed [DATA_W-1:0] res_g_reg [0:2];
    logic                     status_reg;
    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] gx_reg;
    logic signed [DATA_W-1:0] gy_reg;
    logic signed [DATA_W-1:0] gz_reg;

    // Shared multiplier operands.
    logic [MAG_W-1:0]  mul_a;
    logic [DATA_W-1:0] mul_b;
    logic              mul_neg;
    logic              rnd_extra;

    // Grid geometry.
    logic [R_W-1:0]  r_eff;
    logic [NB_W-1:0] nb_step;
    logic [NB_W-1:0] nb_hi;
    logic [NB_W-1:0] nb_lo;

    // Store.
    logic [DATA_W-1:0]        mem [DEPTH];
    logic signed [DATA_W-1:0] mem_q;
    logic                     mem_we;
    logic [ADDR_W-1:0]        mem_wa;
    logic [DATA_W-1:0]        mem_wd;
    logic [ADDR_W-1:0]        rd_addr;

    // Divider.
    logic             div_start;
    logic [IDX_W-1:0] div_dvd;
    logic             div_done;
    logic [IDX_W-1:0] div_quo;
    logic [R_W-1:0]   div_rem;

    // A resolution beyond the store size acts as the store size.
    assign r_eff = (int'(grid_res_reg) > MAX_RESOLUTION) ? R_W'(MAX_RESOLUTION)
                                                         : R_W'(grid_res_reg);

    assign cfg_ready = 1'b1;
    assign in_ready  = (st_reg == ST_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign fin_load  = (st_reg == ST_FIN) && (!out_valid_reg || out_ready);
    assign idx_err   = CMP_W'(idx_reg) >= CMP_W'(tot_reg);
    assign scale_now = scale_reg && (kind_reg inside {KIND_ADD, KIND_MUL, KIND_LOGISTIC});

    // Neighbor addresses along the current gradient axis. A missing face
    // neighbor at the grid edge is replaced by the box itself.
    always_comb
    begin
        case (ax_reg)
            2'd0:    nb_step = NB_W'(1);
            2'd1:    nb_step = NB_W'(r_eff);
            default: nb_step = NB_W'(rr_reg);
        endcase
        nb_hi = okp_reg[ax_reg] ? (NB_W'(idx_reg) + nb_step) : NB_W'(idx_reg);
        nb_lo = okm_reg[ax_reg] ? (NB_W'(idx_reg) - nb_step) : NB_W'(idx_reg);
    end

    always_comb
    begin
        case (st_reg)
            ST_GRDH: rd_addr = ADDR_W'(nb_hi);
            ST_GRDL: rd_addr = ADDR_W'(nb_lo);
            default: rd_addr = ADDR_W'(idx_reg);
        endcase
    end

    // The clearing pass and the write-back share the one write port.
    assign mem_we = (st_reg == ST_CLEAR) || (st_reg == ST_WB);
    assign mem_wa = (st_reg == ST_CLEAR) ? clr_cnt_reg : ADDR_W'(idx_reg);
    assign mem_wd = (st_reg == ST_CLEAR) ? '0 : res_value_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        mem_q <= mem[rd_addr];
    end

    // Operand selection for the shared multiplier. Products are taken on
    // magnitudes and the sign is carried beside them.
    always_comb
    begin
        case (ph_reg)
            PH_SCALE:
            begin
                mul_a   = mag_of(MAG_W'(a_reg));
                mul_b   = inv_vol_reg;
                mul_neg = a_reg[DATA_W-1];
            end
            PH_PROD:
            begin
                mul_b = DATA_W'(mag_of(MAG_W'(a_reg)));
                if (kind_reg == KIND_MUL)
                begin
                    mul_a   = mag_of(MAG_W'(c_reg));
                    mul_neg = c_reg[DATA_W-1] ^ a_reg[DATA_W-1];
                end
                else
                begin
                    mul_a   = mag_of(t_reg);
                    mul_neg = t_reg[MAG_W-1] ^ a_reg[DATA_W-1];
                end
            end
            default:
            begin
                mul_a   = mag_of(diff_reg);
                mul_b   = inv_len_reg;
                mul_neg = diff_reg[MAG_W-1];
            end
        endcase
    end

    // A central difference spans two boxes and is halved.
    assign rnd_extra = (ph_reg == PH_GRAD) && okm_reg[ax_reg] && okp_reg[ax_reg];

    assign div_start = (st_reg == ST_DV1) || (st_reg == ST_DV2);
    assign div_dvd   = (st_reg == ST_DV2) ? q1_reg : idx_reg;

    vcs_div #(
        .DIVIDEND_W (IDX_W),
        .DIVISOR_W  (R_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (r_eff),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Sequencer.
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == ADDR_W'(DEPTH - 1))
                begin
                    st_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    st_next = ST_RR;
                end
            end
            ST_RR:    st_next = ST_TOT;
            ST_TOT:   st_next = ST_CHK;
            ST_CHK:   st_next = idx_err ? ST_FIN : ST_LOADC;
            ST_LOADC: st_next = scale_now ? ST_MUL : ST_OPSEL;
            ST_OPSEL:
            begin
                case (kind_reg)
                    KIND_MUL, KIND_LOGISTIC: st_next = ST_MUL;
                    KIND_GRAD:               st_next = ST_DV1;
                    default:                 st_next = ST_WB;
                endcase
            end
            ST_MUL:   st_next = ST_RND;
            ST_RND:   st_next = ST_POST;
            ST_POST:
            begin
                case (ph_reg)
                    PH_SCALE: st_next = ST_OPSEL;
                    PH_PROD:  st_next = ST_WB;
                    default:  st_next = (ax_reg == AX_Z) ? ST_WB : ST_GRDH;
                endcase
            end
            ST_DV1:   st_next = ST_DV1W;
            ST_DV1W:
            begin
                if (div_done)
                begin
                    st_next = ST_DV2;
                end
            end
            ST_DV2:   st_next = ST_DV2W;
            ST_DV2W:
            begin
                if (div_done)
                begin
                    st_next = ST_GSET;
                end
            end
            ST_GSET:  st_next = ST_GRDH;
            ST_GRDH:  st_next = ST_GRDL;
            ST_GRDL:  st_next = ST_GDIF;
            ST_GDIF:  st_next = ST_MUL;
            ST_WB:    st_next = ST_FIN;
            ST_FIN:
            begin
                if (fin_load)
                begin
                    st_next = ST_IDLE;
                end
            end
            default:  st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            ph_reg        <= PH_SCALE;
            ax_reg        <= '0;
            out_valid_reg <= 1'b0;
            grid_res_reg  <= RST_GRID_RES;
            lower_reg     <= RST_LOWER;
            upper_reg     <= RST_UPPER;
            inv_len_reg   <= RST_INV_LEN;
            inv_vol_reg   <= RST_INV_VOL;
        end
        else
        begin
            st_reg <= st_next;
            if (st_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
            case (st_reg)
                ST_LOADC: ph_reg <= PH_SCALE;
                ST_OPSEL:
                begin
                    ph_reg <= PH_PROD;
                    ax_reg <= '0;
                end
                ST_GDIF:  ph_reg <= PH_GRAD;
                ST_POST:
                begin
                    if (ph_reg == PH_GRAD)
                    begin
                        ax_reg <= ax_reg + 2'd1;
                    end
                end
                default:  ;
            endcase
            if (fin_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_GRID_RES: grid_res_reg <= cfg_data[RES_W-1:0];
                    CFG_LOWER:    lower_reg    <= cfg_data;
                    CFG_UPPER:    upper_reg    <= cfg_data;
                    CFG_INV_LEN:  inv_len_reg  <= cfg_data;
                    CFG_INV_VOL:  inv_vol_reg  <= cfg_data;
                    default:      ;
                endcase
            end
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        case (st_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    kind_reg  <= kind;
                    idx_reg   <= box_index;
                    a_reg     <= amount;
                    scale_reg <= scale_by_volume;
                end
            end
            ST_RR:  rr_reg  <= RR_W'(r_eff) * RR_W'(r_eff);
            ST_TOT: tot_reg <= TOT_W'(rr_reg) * TOT_W'(r_eff);
            ST_CHK:
            begin
                // An index outside the grid returns the error status with
                // every value field zero, and the store is left alone.
                res_status_reg <= idx_err;
                res_value_reg  <= '0;
                res_g_reg[0]   <= '0;
                res_g_reg[1]   <= '0;
                res_g_reg[2]   <= '0;
            end
            ST_LOADC: c_reg <= mem_q;
            ST_OPSEL:
            begin
                case (kind_reg)
                    KIND_WRITE:
                        res_value_reg <= clamp_thr(WIDE_W'(a_reg), lower_reg, upper_reg);
                    KIND_ADD:
                        res_value_reg <= clamp_thr(WIDE_W'(c_reg) + WIDE_W'(a_reg),
                                                   lower_reg, upper_reg);
                    KIND_MUL:
                        ;
                    KIND_LOGISTIC:
                        // Grow toward the upper threshold for a positive rate,
                        // otherwise scale by the distance above the lower one.
                        t_reg <= (a_reg > 0) ? (MAG_W'(upper_reg) - MAG_W'(c_reg))
                                             : (MAG_W'(c_reg) - MAG_W'(lower_reg));
                    default:
                        res_value_reg <= c_reg;
                endcase
            end
            ST_MUL:
            begin
                prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
                neg_reg  <= mul_neg;
            end
            ST_RND: rnd_reg <= round_shift(neg_reg, prod_reg, rnd_extra);
            ST_POST:
            begin
                case (ph_reg)
                    PH_SCALE: a_reg <= sat32(WIDE_W'(rnd_reg));
                    PH_PROD:
                    begin
                        if (kind_reg == KIND_MUL)
                        begin
                            res_value_reg <= clamp_thr(WIDE_W'(rnd_reg), lower_reg, upper_reg);
                        end
                        else
                        begin
                            res_value_reg <= clamp_thr(WIDE_W'(c_reg) + WIDE_W'(rnd_reg),
                                                       lower_reg, upper_reg);
                        end
                    end
                    default:
                    begin
                        // No neighbor on either side gives a zero component.
                        if (!okm_reg[ax_reg] && !okp_reg[ax_reg])
                        begin
                            res_g_reg[ax_reg] <= '0;
                        end
                        else
                        begin
                            res_g_reg[ax_reg] <= sat32(WIDE_W'(rnd_reg));
                        end
                    end
                endcase
            end
            ST_DV1W:
            begin
                if (div_done)
                begin
                    x_reg  <= div_rem;
                    q1_reg <= div_quo;
                end
            end
            ST_DV2W:
            begin
                if (div_done)
                begin
                    y_reg <= div_rem;
                    z_reg <= R_W'(div_quo);
                end
            end
            ST_GSET:
            begin
                okm_reg <= {z_reg != '0, y_reg != '0, x_reg != '0};
                okp_reg <= {z_reg != (r_eff - R_W'(1)),
                            y_reg != (r_eff - R_W'(1)),
                            x_reg != (r_eff - R_W'(1))};
            end
            ST_GRDL: hv_reg   <= mem_q;
            ST_GDIF: diff_reg <= MAG_W'(hv_reg) - MAG_W'(mem_q);
            ST_FIN:
            begin
                if (fin_load)
                begin
                    status_reg <= res_status_reg;
                    value_reg  <= res_value_reg;
                    gx_reg     <= res_g_reg[0];
                    gy_reg     <= res_g_reg[1];
                    gz_reg     <= res_g_reg[2];
                end
            end
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign value     = value_reg;
    assign grad_x    = gx_reg;
    assign grad_y    = gy_reg;
    assign grad_z    = gz_reg;

endmodule

// File: hw/rtl/vcs_checker.sv
// ----------------------------------------------------------------------------
// vcs_checker: port-level assertions for the voxel concentration store
// Watches the item channels of the top level and is attached by bind.
// ----------------------------------------------------------------------------
module vcs_checker
    import vcs_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic                     status,
    input logic signed [DATA_W-1:0] value,
    input logic signed [DATA_W-1:0] grad_x,
    input logic signed [DATA_W-1:0] grad_y,
    input logic signed [DATA_W-1:0] grad_z
);

    logic [1:0] pending_reg;

    // Items accepted whose result has not yet been taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + 2'((in_valid && in_ready) ? 1 : 0)
                                       - 2'((out_valid && out_ready) ? 1 : 0);
        end
    end

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status) |-> (value == 0 && grad_x == 0 && grad_y == 0 && grad_z == 0))
        else $error("error result carries nonzero fields");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("item accepted while another is in work");

    a_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg <= 2'd2) && (!out_valid || pending_reg != 2'd0))
        else $error("result without an accepted item, or too many in flight");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(value) && $stable(status)))
        else $error("stalled result changed");

endmodule

bind voxel_concentration_store_unit vcs_checker u_vcs_checker (.*);

// File: bench/vcs_checker.sv
// ----------------------------------------------------------------------------
// vcs_result_checker: result predictor and comparator for the voxel store
// Watches the config, request and result channels, keeps its own copy of the
// store and registers, and compares every result with the oldest prediction.
// ----------------------------------------------------------------------------
module vcs_result_checker
    import vcs_pkg::*;
#(
    parameter int MAX_RESOLUTION = DEFAULT_MAX_RES,
    parameter int FRAC_BITS      = DEFAULT_FRAC_BITS
)(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [CFG_W-1:0]         cfg_index,
    input  logic [DATA_W-1:0]        cfg_data,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  logic [KIND_W-1:0]        kind,
    input  logic [IDX_W-1:0]         box_index,
    input  logic signed [DATA_W-1:0] amount,
    input  logic                     scale_by_volume,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  logic                     status,
    input  logic signed [DATA_W-1:0] value,
    input  logic signed [DATA_W-1:0] grad_x,
    input  logic signed [DATA_W-1:0] grad_y,
    input  logic signed [DATA_W-1:0] grad_z,
    output int                       pending,
    output int                       fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = MAX_RESOLUTION * MAX_RESOLUTION * MAX_RESOLUTION;

    typedef struct packed {
        logic              status;
        logic signed [31:0] value;
        logic signed [31:0] gx;
        logic signed [31:0] gy;
        logic signed [31:0] gz;
    } voxel_result_t;

    logic signed [31:0] conc_mirror [DEPTH];
    logic [RES_W-1:0]   res_reg;
    longint             lower_reg;
    longint             upper_reg;
    longint             inv_len_reg;
    longint             inv_vol_reg;
    voxel_result_t      expected_results [$];

    // Rounds half away from zero after dropping the given fraction bits.
    function automatic longint round_shift(longint x, int s);
        longint mag;
        mag = (x < 0) ? -x : x;
        mag = (mag + (longint'(1) << (s - 1))) >>> s;
        return (x < 0) ? -mag : mag;
    endfunction

    function automatic longint sat32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint clamp_thr(longint x);
        if (x > upper_reg) return upper_reg;
        if (x < lower_reg) return lower_reg;
        return x;
    endfunction

    // Products here can exceed 64 bits when both operands are near full
    // scale, so the gradient multiply works on 128-bit magnitudes.
    function automatic longint axis_slope(int lo, int hi, int span);
        longint diff;
        logic [127:0] m;
        if (span == 0) return 0;
        diff = longint'(conc_mirror[hi]) - longint'(conc_mirror[lo]);
        m = 128'((diff < 0) ? -diff : diff) * 128'(inv_len_reg);
        m = (m + (128'd1 << (FRAC_BITS + span - 2))) >> (FRAC_BITS + span - 1);
        if (m > 128'd2147483648) m = 128'd2147483648;
        return sat32((diff < 0) ? -longint'(m) : longint'(m));
    endfunction

    function automatic voxel_result_t predict_voxel(logic [KIND_W-1:0] k, int idx,
                                                    longint a, logic scl);
        voxel_result_t res;
        int r, rr, x, y, z, xm, xp, ym, yp, zm, zp;
        longint c, nv, t, p;
        logic [127:0] m;
        res = '0;
        r = (res_reg > MAX_RESOLUTION) ? MAX_RESOLUTION : int'(res_reg);
        rr = r * r;
        if (idx >= rr * r) begin
            res.status = 1'b1;
            return res;
        end
        c = conc_mirror[idx];
        nv = c;
        if (k inside {KIND_ADD, KIND_MUL, KIND_LOGISTIC} && scl) begin
            m = 128'((a < 0) ? -a : a) * 128'(inv_vol_reg);
            m = (m + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
            if (m > 128'h1_0000_0000) m = 128'h1_0000_0000;
            a = sat32((a < 0) ? -longint'(m) : longint'(m));
        end
        case (k)
            KIND_WRITE: nv = clamp_thr(a);
            KIND_ADD: nv = clamp_thr(c + a);
            KIND_MUL: nv = clamp_thr(round_shift(c * a, FRAC_BITS));
            KIND_LOGISTIC:
            begin
                t = (a > 0) ? upper_reg - c : c - lower_reg;
                p = t * a;
                nv = clamp_thr(c + round_shift(p, FRAC_BITS));
            end
            KIND_GRAD:
            begin
                x = idx % r;
                y = (idx / r) % r;
                z = idx / rr;
                xm = (x == 0) ? idx : idx - 1;
                xp = (x == r - 1) ? idx : idx + 1;
                ym = (y == 0) ? idx : idx - r;
                yp = (y == r - 1) ? idx : idx + r;
                zm = (z == 0) ? idx : idx - rr;
                zp = (z == r - 1) ? idx : idx + rr;
                res.gx = 32'(axis_slope(xm, xp, int'(xm != idx) + int'(xp != idx)));
                res.gy = 32'(axis_slope(ym, yp, int'(ym != idx) + int'(yp != idx)));
                res.gz = 32'(axis_slope(zm, zp, int'(zm != idx) + int'(zp != idx)));
            end
            default: ;
        endcase
        conc_mirror[idx] = nv[31:0];
        res.value = nv[31:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        voxel_result_t want;
        if (!rst_n) begin
            foreach (conc_mirror[i]) conc_mirror[i] = '0;
            res_reg = RST_GRID_RES;
            lower_reg = RST_LOWER;
            upper_reg = RST_UPPER;
            inv_len_reg = RST_INV_LEN;
            inv_vol_reg = RST_INV_VOL;
            expected_results.delete();
            pending = 0;
            fail_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_GRID_RES: res_reg = cfg_data[RES_W-1:0];
                    CFG_LOWER: lower_reg = longint'(signed'(cfg_data));
                    CFG_UPPER: upper_reg = longint'(signed'(cfg_data));
                    CFG_INV_LEN: inv_len_reg = longint'(cfg_data);
                    CFG_INV_VOL: inv_vol_reg = longint'(cfg_data);
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                expected_results.push_back(predict_voxel(kind, int'(box_index),
                    longint'(amount), scale_by_volume));
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result arrived with no request outstanding");
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, status);
                        fail_count++;
                    end
                    if (value !== want.value) begin
                        $error("value: expected %0d, actual %0d", want.value, value);
                        fail_count++;
                    end
                    if (grad_x !== want.gx) begin
                        $error("grad_x: expected %0d, actual %0d", want.gx, grad_x);
                        fail_count++;
                    end
                    if (grad_y !== want.gy) begin
                        $error("grad_y: expected %0d, actual %0d", want.gy, grad_y);
                        fail_count++;
                    end
                    if (grad_z !== want.gz) begin
                        $error("grad_z: expected %0d, actual %0d", want.gz, grad_z);
                        fail_count++;
                    end
                end
            end
            pending = expected_results.size();
        end
    end

endmodule

// File: bench/tb_voxel_concentration_store_unit.sv
// ----------------------------------------------------------------------------
// tb_voxel_concentration_store_unit: request stimulus and verdict
// Drives configuration phases, directed corner requests and random request
// streams under several idling patterns; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_voxel_concentration_store_unit;
    import vcs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // The store clears itself after reset, and a gradient is the slowest item;
    // the limit leaves many times the slowest run.
    localparam longint CYCLE_LIMIT = 1500000;
    localparam int     DRAIN_CYCLES = 80;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_W-1:0]         cfg_index;
    logic [DATA_W-1:0]        cfg_data;
    logic                     in_valid;
    logic                     in_ready;
    logic [KIND_W-1:0]        kind;
    logic [IDX_W-1:0]         box_index;
    logic signed [DATA_W-1:0] amount;
    logic                     scale_by_volume;
    logic                     out_valid;
    logic                     out_ready;
    logic                     status;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] grad_x;
    logic signed [DATA_W-1:0] grad_y;
    logic signed [DATA_W-1:0] grad_z;
    int                       pending;
    int                       fail_count;

    // Idle and stall rates in percent for the current phase.
    int                       send_idle_pct;
    int                       recv_stall_pct;
    int                       cur_res;
    longint                   cycle_count;

    voxel_concentration_store_unit i_dut (.*);

    vcs_result_checker i_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run guard: any hang ends the run as a failure.
    initial
    begin
        cycle_count = 0;
        forever begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // The receiver stalls at random according to the current phase.
    initial
    begin
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Each write drives valid, index and data at a falling edge and holds them until the register is taken.
    task automatic write_reg(logic [CFG_W-1:0] idx, logic [DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_GRID_RES) cur_res = (data[5:0] > 32) ? 32 : int'(data[5:0]);
    endtask

    // Sends one request; the sender may idle first, and valid is held
    // until the block takes the item.
    task automatic send_request(logic [KIND_W-1:0] k, logic [IDX_W-1:0] idx,
                                logic [DATA_W-1:0] a, logic scl);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) @(negedge clk);
        in_valid <= 1'b1;
        kind <= k;
        box_index <= idx;
        amount <= a;
        scale_by_volume <= scl;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Waits for every predicted result and then lets the block settle.
    task automatic drain();
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic logic [DATA_W-1:0] random_amount();
        case ($urandom_range(4))
            0: return $urandom();
            1: return $urandom_range(262143) - 131072;
            2: return $urandom_range(1, 65536);
            3: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
            default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
    endfunction

    // Mostly indexes inside the grid, biased to the edges, sometimes outside.
    function automatic logic [IDX_W-1:0] random_index();
        int total;
        total = cur_res * cur_res * cur_res;
        if (total == 0 || $urandom_range(9) == 0) return IDX_W'($urandom());
        if ($urandom_range(3) == 0) return ($urandom_range(1) != 0) ? '0 : IDX_W'(total - 1);
        return IDX_W'($urandom_range(total - 1));
    endfunction

    task automatic random_burst(int count);
        logic [KIND_W-1:0] k;
        for (int n = 0; n < count; n++) begin
            k = KIND_W'($urandom_range(7));
            send_request(k, random_index(), random_amount(), 1'($urandom_range(1)));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        kind = KIND_READ;
        box_index = '0;
        amount = '0;
        scale_by_volume = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        cur_res = 16;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Directed part at a small grid with wide thresholds.
        write_reg(CFG_GRID_RES, 32'd3);
        write_reg(CFG_LOWER, 32'h8000_0000);
        write_reg(CFG_UPPER, 32'h7FFF_FFFF);
        write_reg(CFG_INV_LEN, 32'd65536);
        write_reg(CFG_INV_VOL, 32'd32768);
        send_request(KIND_WRITE, 15'd13, 32'h0003_0000, 1'b1);
        send_request(KIND_WRITE, 15'd14, 32'h7FFF_FFFF, 1'b0);
        send_request(KIND_WRITE, 15'd12, 32'h8000_0000, 1'b0);
        send_request(KIND_WRITE, 15'd16, 32'h0001_8000, 1'b0);
        send_request(KIND_WRITE, 15'd22, 32'hFFFF_0000, 1'b0);
        send_request(KIND_GRAD, 15'd13, 32'd0, 1'b0);
        send_request(KIND_GRAD, 15'd0, 32'd0, 1'b0);
        send_request(KIND_GRAD, 15'd26, 32'd0, 1'b0);
        send_request(KIND_ADD, 15'd13, 32'h0001_0000, 1'b1);
        send_request(KIND_ADD, 15'd14, 32'h7FFF_FFFF, 1'b0);
        send_request(KIND_MUL, 15'd13, 32'hFFFE_8000, 1'b0);
        send_request(KIND_MUL, 15'd16, 32'h7FFF_FFFF, 1'b1);
        send_request(KIND_LOGISTIC, 15'd13, 32'h0000_8000, 1'b0);
        send_request(KIND_LOGISTIC, 15'd22, 32'hFFFF_C000, 1'b1);
        send_request(KIND_READ, 15'd13, 32'd0, 1'b0);
        send_request(3'd6, 15'd14, 32'd0, 1'b0);
        send_request(3'd7, 15'd27, 32'd0, 1'b0);
        send_request(KIND_READ, 15'h7FFF, 32'hFFFF_FFFF, 1'b1);
        drain();

        // A single-box grid has no neighbours at all; then a zero grid.
        write_reg(CFG_GRID_RES, 32'd1);
        send_request(KIND_GRAD, 15'd0, 32'd0, 1'b0);
        send_request(KIND_WRITE, 15'd1, 32'd5, 1'b0);
        drain();
        write_reg(CFG_GRID_RES, 32'd0);
        send_request(KIND_READ, 15'd0, 32'd0, 1'b0);
        drain();

        // Oversized resolution acts as the largest grid; huge scale factors
        // saturate the scaled amount and the gradient.
        write_reg(CFG_GRID_RES, 32'd63);
        write_reg(CFG_INV_LEN, 32'hFFFF_FFFF);
        write_reg(CFG_INV_VOL, 32'hFFFF_FFFF);
        send_request(KIND_WRITE, 15'd32767, 32'h7FFF_FFFF, 1'b0);
        send_request(KIND_GRAD, 15'd31743, 32'd0, 1'b0);
        send_request(KIND_ADD, 15'd1, 32'hFFFF_FFFF, 1'b1);
        send_request(KIND_LOGISTIC, 15'd0, 32'h8000_0000, 1'b1);
        drain();

        // Random phases, each with its own settings and idling pattern.
        for (int phase = 0; phase < 8; phase++) begin
            write_reg(CFG_GRID_RES, (phase == 7) ? 32'd32 : $urandom_range(2, 6));
            write_reg(CFG_LOWER, (phase % 3 == 0) ? 32'h8000_0000
                                 : $urandom_range(1) ? 32'd0 : random_amount());
            write_reg(CFG_UPPER, (phase % 3 == 0) ? 32'h7FFF_FFFF
                                 : $urandom_range(1) ? 32'h0100_0000 : random_amount());
            write_reg(CFG_INV_LEN, (phase == 5) ? 32'd0 : $urandom());
            write_reg(CFG_INV_VOL, (phase == 6) ? 32'd0 : $urandom_range(1) ? $urandom()
                                   : $urandom_range(131072));
            case (phase % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 88; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 88; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            random_burst(35);
            // Hold off until everything in flight has come back.
            while (pending != 0) @(negedge clk);
            random_burst(35);
            drain();
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
